@@ rtl/running_median_two_heaps_core_macros.svh @@
// Assertion macros for the running median core.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_MACROS_SVH
`ifndef SYNTH
`define RMTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RMTH_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`else
`define RMTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RMTH_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/rmth_pkg.sv @@
// Shared types, constants and helpers for the running median core.
package rmth_pkg;

    typedef logic signed [31:0] value_t;
    typedef logic signed [32:0] median_t;
    typedef logic [10:0]        count_t;

    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    function automatic logic goes_first(value_t a, value_t b, logic is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

endpackage

@@ rtl/rmth_in_if.sv @@
// Input channel: one sample per item.
interface rmth_in_if;
    logic               valid;
    logic               ready;
    rmth_pkg::value_t   value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

@@ rtl/rmth_out_if.sv @@
// Output channel: median, count and drop flag per item.
interface rmth_out_if;
    logic               valid;
    logic               ready;
    rmth_pkg::median_t  median_x2;
    rmth_pkg::count_t   count;
    logic               dropped;

    modport source (output valid, output median_x2, output count, output dropped, input ready);
    modport sink (input valid, input median_x2, input count, input dropped, output ready);
endinterface

@@ rtl/rmth_ram.sv @@
// Single-port-write, registered-read heap storage.
module rmth_ram #(
    parameter int DEPTH = 514,
    parameter int AW    = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  rmth_pkg::value_t  wdata,
    input  logic [AW-1:0]     raddr,
    output rmth_pkg::value_t  rdata
);

    rmth_pkg::value_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/running_median_two_heaps_core.sv @@
// Running median core: a max-heap and a min-heap held in two synchronous RAMs.
//
// Channels: sample (value in) and result (median_x2, count, dropped out),
// valid/ready, an item moves when both are high.
// Each sample is inserted into the lower (max) or upper (min) heap, then one
// top moves across where needed, so the lower heap holds as many values as
// the upper or one more. Each item returns twice the median, the count held
// and a drop flag set when the store already held CAPACITY values.
// Steps: a sift-up, then an optional sift-down and second sift-up; a dropped
// item skips all of them. One item is in work at a time: the single read
// port of each heap RAM sets the pace.
// Reset clears the counts; heap RAM contents need no clearing since only
// entries below the counts are read.
// A stalled receiver holds the result in the output register; the next item
// is taken and worked on meanwhile, and its result waits until that
// register frees.
module running_median_two_heaps_core #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    rmth_in_if.sink     sample,
    rmth_out_if.source  result
);

`include "running_median_two_heaps_core_macros.svh"

    localparam int HEAP_DEPTH = CAPACITY / 2 + 2;
    localparam int AW  = $clog2(HEAP_DEPTH);
    localparam int HW  = $clog2(HEAP_DEPTH + 1);
    localparam int CW0 = $clog2(CAPACITY + 1);
    localparam int TW  = (CW0 > 11) ? CW0 : 11;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_CHK  = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_REBAL   = 4'd3;
    localparam logic [3:0] S_DN_LAST = 4'd4;
    localparam logic [3:0] S_DN_L    = 4'd5;
    localparam logic [3:0] S_DN_R    = 4'd6;
    localparam logic [3:0] S_DN_CMP  = 4'd7;
    localparam logic [3:0] S_INS2    = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic              sel_reg, sel_next;
    logic              rebal_reg, rebal_next;
    logic              dropped_reg, dropped_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     par_reg, par_next;
    logic [AW-1:0]     lim_reg, lim_next;
    logic [AW:0]       child_reg, child_next;
    rmth_pkg::value_t  val_reg, val_next;
    rmth_pkg::value_t  lval_reg, lval_next;
    rmth_pkg::value_t  take_reg, take_next;
    rmth_pkg::value_t  ltop_reg, ltop_next;
    rmth_pkg::value_t  utop_reg, utop_next;
    logic [HW-1:0]     lc_reg, lc_next;
    logic [HW-1:0]     uc_reg, uc_next;
    logic              out_valid_reg;
    rmth_pkg::median_t out_med_reg;
    rmth_pkg::count_t  out_cnt_reg;
    logic              out_drop_reg;

    logic              we, we_l, we_u, load_out;
    logic [AW-1:0]     waddr, raddr;
    rmth_pkg::value_t  wdata, rdata_l, rdata_u, rdata_sel, bestv;
    logic              is_max, r_ok;
    logic [1:0]        pick;
    logic [AW:0]       child_l, child_r;
    logic [HW-1:0]     m_tmp;
    logic [TW-1:0]     total;
    rmth_pkg::median_t med;

    assign rdata_sel = (sel_reg == rmth_pkg::HEAP_UPPER) ? rdata_u : rdata_l;
    assign is_max    = (sel_reg == rmth_pkg::HEAP_LOWER);
    assign total     = TW'(lc_reg) + TW'(uc_reg);
    assign child_l   = {idx_reg, 1'b1};
    assign child_r   = child_reg + (AW + 1)'(1);
    assign r_ok      = child_r < {1'b0, lim_reg};
    assign we_l      = we && (sel_reg == rmth_pkg::HEAP_LOWER);
    assign we_u      = we && (sel_reg == rmth_pkg::HEAP_UPPER);
    assign sample.ready = (state_reg == S_IDLE);

    always_comb
    begin
        if (lc_reg == '0)
        begin
            med = '0;
        end
        else if (lc_reg == uc_reg)
        begin
            med = {ltop_reg[31], ltop_reg} + {utop_reg[31], utop_reg};
        end
        else
        begin
            med = {ltop_reg, 1'b0};
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        rebal_next   = rebal_reg;
        dropped_next = dropped_reg;
        idx_next     = idx_reg;
        par_next     = par_reg;
        lim_next     = lim_reg;
        child_next   = child_reg;
        val_next     = val_reg;
        lval_next    = lval_reg;
        take_next    = take_reg;
        ltop_next    = ltop_reg;
        utop_next    = utop_reg;
        lc_next      = lc_reg;
        uc_next      = uc_reg;
        we           = 1'b0;
        waddr        = idx_reg;
        wdata        = val_reg;
        raddr        = par_reg;
        load_out     = 1'b0;
        bestv        = val_reg;
        pick         = 2'd0;
        m_tmp        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    if (total >= TW'(CAPACITY))
                    begin
                        dropped_next = 1'b1;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        dropped_next = 1'b0;
                        rebal_next   = 1'b0;
                        val_next     = sample.value;
                        if (lc_reg == '0 || sample.value <= ltop_reg)
                        begin
                            sel_next = rmth_pkg::HEAP_LOWER;
                            idx_next = AW'(lc_reg);
                            lc_next  = lc_reg + HW'(1);
                        end
                        else
                        begin
                            sel_next = rmth_pkg::HEAP_UPPER;
                            idx_next = AW'(uc_reg);
                            uc_next  = uc_reg + HW'(1);
                        end
                        state_next = S_UP_CHK;
                    end
                end
            end
            S_UP_CHK:
            begin
                if (idx_reg == '0)
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = val_reg;
                    state_next = rebal_reg ? S_OUT : S_REBAL;
                end
                else
                begin
                    par_next   = (idx_reg - AW'(1)) >> 1;
                    raddr      = (idx_reg - AW'(1)) >> 1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                if (rmth_pkg::goes_first(val_reg, rdata_sel, is_max))
                begin
                    wdata      = rdata_sel;
                    idx_next   = par_reg;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    wdata      = val_reg;
                    state_next = rebal_reg ? S_OUT : S_REBAL;
                end
            end
            S_REBAL:
            begin
                rebal_next = 1'b1;
                if ({1'b0, lc_reg} == {1'b0, uc_reg} + (HW + 1)'(2))
                begin
                    sel_next  = rmth_pkg::HEAP_LOWER;
                    take_next = ltop_reg;
                    m_tmp     = lc_reg - HW'(1);
                    lc_next   = m_tmp;
                    lim_next  = AW'(m_tmp);
                    raddr     = AW'(m_tmp);
                    state_next = (m_tmp == '0) ? S_INS2 : S_DN_LAST;
                end
                else if ({1'b0, uc_reg} == {1'b0, lc_reg} + (HW + 1)'(1))
                begin
                    sel_next  = rmth_pkg::HEAP_UPPER;
                    take_next = utop_reg;
                    m_tmp     = uc_reg - HW'(1);
                    uc_next   = m_tmp;
                    lim_next  = AW'(m_tmp);
                    raddr     = AW'(m_tmp);
                    state_next = (m_tmp == '0) ? S_INS2 : S_DN_LAST;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DN_LAST:
            begin
                val_next   = rdata_sel;
                idx_next   = '0;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (child_l < {1'b0, lim_reg})
                begin
                    child_next = child_l;
                    raddr      = child_l[AW-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = idx_reg;
                    wdata      = val_reg;
                    state_next = S_INS2;
                end
            end
            S_DN_R:
            begin
                lval_next  = rdata_sel;
                raddr      = child_r[AW-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (rmth_pkg::goes_first(lval_reg, bestv, is_max))
                begin
                    bestv = lval_reg;
                    pick  = 2'd1;
                end
                if (r_ok && rmth_pkg::goes_first(rdata_sel, bestv, is_max))
                begin
                    bestv = rdata_sel;
                    pick  = 2'd2;
                end
                we    = 1'b1;
                waddr = idx_reg;
                wdata = bestv;
                if (pick == 2'd0)
                begin
                    state_next = S_INS2;
                end
                else
                begin
                    idx_next   = (pick == 2'd1) ? child_reg[AW-1:0] : child_r[AW-1:0];
                    state_next = S_DN_L;
                end
            end
            S_INS2:
            begin
                val_next = take_reg;
                if (sel_reg == rmth_pkg::HEAP_LOWER)
                begin
                    sel_next = rmth_pkg::HEAP_UPPER;
                    idx_next = AW'(uc_reg);
                    uc_next  = uc_reg + HW'(1);
                end
                else
                begin
                    sel_next = rmth_pkg::HEAP_LOWER;
                    idx_next = AW'(lc_reg);
                    lc_next  = lc_reg + HW'(1);
                end
                state_next = S_UP_CHK;
            end
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (we && waddr == '0)
        begin
            if (sel_reg == rmth_pkg::HEAP_UPPER)
            begin
                utop_next = wdata;
            end
            else
            begin
                ltop_next = wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lc_reg        <= '0;
            uc_reg        <= '0;
            rebal_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            uc_reg    <= uc_next;
            rebal_reg <= rebal_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg     <= sel_next;
        dropped_reg <= dropped_next;
        idx_reg     <= idx_next;
        par_reg     <= par_next;
        lim_reg     <= lim_next;
        child_reg   <= child_next;
        val_reg     <= val_next;
        lval_reg    <= lval_next;
        take_reg    <= take_next;
        ltop_reg    <= ltop_next;
        utop_reg    <= utop_next;
        if (load_out)
        begin
            out_med_reg  <= med;
            out_cnt_reg  <= total[10:0];
            out_drop_reg <= dropped_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.median_x2 = out_med_reg;
    assign result.count     = out_cnt_reg;
    assign result.dropped   = out_drop_reg;

    rmth_ram #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_lower (
        .clk   (clk),
        .we    (we_l),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_l)
    );

    rmth_ram #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_upper (
        .clk   (clk),
        .we    (we_u),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_u)
    );

    `RMTH_ASSERT_IMP(a_balanced, clk, rst_n, state_reg == S_IDLE,
        lc_reg == uc_reg || {1'b0, lc_reg} == {1'b0, uc_reg} + (HW + 1)'(1))
    `RMTH_ASSERT_IMP(a_capacity, clk, rst_n, state_reg == S_IDLE, total <= TW'(CAPACITY))
    `RMTH_ASSERT_IMP(a_ordered, clk, rst_n,
        state_reg == S_IDLE && lc_reg != '0 && uc_reg != '0, ltop_reg <= utop_reg)

endmodule

@@ tb/sv/tb_running_median_two_heaps_core.sv @@
// Testbench for the running median core: table-driven and random samples checked by a predictor.
module tb_running_median_two_heaps_core;

    localparam int CAP = 1024;
    localparam int HALF = CAP / 2 + 2;
    localparam int N_DIRECTED = 16;
    localparam int N_RANDOM = 1134;

    typedef struct packed {
        rmth_pkg::median_t median_x2;
        rmth_pkg::count_t  count;
        logic              dropped;
    } median_res_t;

    typedef struct {
        rmth_pkg::value_t  value;
        logic              known;
        rmth_pkg::median_t median_x2;
        rmth_pkg::count_t  count;
    } sample_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rmth_in_if  sample_ch ();
    rmth_out_if result_ch ();

    running_median_two_heaps_core #(.CAPACITY(CAP)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch),
        .result(result_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    rmth_pkg::value_t lo_heap[HALF];
    rmth_pkg::value_t hi_heap[HALF];
    int unsigned lo_n = 0;
    int unsigned hi_n = 0;
    median_res_t pending[$];
    int errors = 0;
    int send_idle = 27;
    int recv_idle = 0;
    logic hold_off = 1'b0;

    function automatic logic prior(rmth_pkg::value_t a, rmth_pkg::value_t b, logic is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_push(ref rmth_pkg::value_t h[HALF], ref int unsigned n,
                             input rmth_pkg::value_t v, input logic is_max);
        int unsigned i;
        int unsigned p;
        rmth_pkg::value_t t;
        i = n;
        h[i] = v;
        n = i + 1;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!prior(h[i], h[p], is_max))
                break;
            t = h[i]; h[i] = h[p]; h[p] = t;
            i = p;
        end
    endtask

    task automatic heap_pop(ref rmth_pkg::value_t h[HALF], ref int unsigned n,
                            input logic is_max, output rmth_pkg::value_t top);
        int unsigned m;
        int unsigned i;
        int unsigned l;
        int unsigned best;
        rmth_pkg::value_t t;
        top = h[0];
        m = n - 1;
        n = m;
        h[0] = h[m];
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            best = i;
            if (l < m && prior(h[l], h[best], is_max))
                best = l;
            if (l + 1 < m && prior(h[l + 1], h[best], is_max))
                best = l + 1;
            if (best == i)
                break;
            t = h[i]; h[i] = h[best]; h[best] = t;
            i = best;
        end
    endtask

    task automatic predict_median(input rmth_pkg::value_t v);
        median_res_t r;
        rmth_pkg::value_t t;
        longint m;
        r.dropped = 1'b0;
        if (lo_n + hi_n >= CAP)
            r.dropped = 1'b1;
        else
        begin
            if (lo_n == 0 || v <= lo_heap[0])
                heap_push(lo_heap, lo_n, v, 1'b1);
            else
                heap_push(hi_heap, hi_n, v, 1'b0);
            if (lo_n == hi_n + 2)
            begin
                heap_pop(lo_heap, lo_n, 1'b1, t);
                heap_push(hi_heap, hi_n, t, 1'b0);
            end
            else if (hi_n == lo_n + 1)
            begin
                heap_pop(hi_heap, hi_n, 1'b0, t);
                heap_push(lo_heap, lo_n, t, 1'b1);
            end
        end
        if (lo_n == 0)
            m = 0;
        else if (lo_n == hi_n)
            m = longint'(lo_heap[0]) + longint'(hi_heap[0]);
        else
            m = 2 * longint'(lo_heap[0]);
        r.median_x2 = rmth_pkg::median_t'(m);
        r.count = rmth_pkg::count_t'(lo_n + hi_n);
        pending.push_back(r);
    endtask

    task automatic send_sample(input rmth_pkg::value_t v);
        while (send_idle > 0 && $urandom_range(99, 0) < send_idle)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.value <= v;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predict_median(v);
        @(negedge clk);
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_off)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !(recv_idle > 0 && $urandom_range(99, 0) < recv_idle);
    end

    always @(posedge clk)
    begin
        median_res_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result median_x2=%0d count=%0d dropped=%0b",
                         $time, result_ch.median_x2, result_ch.count, result_ch.dropped);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (result_ch.median_x2 !== want.median_x2 || result_ch.count !== want.count
                    || result_ch.dropped !== want.dropped)
                begin
                    $display("%0t: expected median_x2=%0d count=%0d dropped=%0b, got %0d %0d %0b",
                             $time, want.median_x2, want.count, want.dropped,
                             result_ch.median_x2, result_ch.count, result_ch.dropped);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #60000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic rmth_pkg::value_t rand_value(int mode);
        case (mode)
            0: return rmth_pkg::value_t'($urandom);
            1: return rmth_pkg::value_t'($urandom_range(40, 0)) - 20;
            2: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
            default: return rmth_pkg::value_t'($urandom_range(1000, 0));
        endcase
    endfunction

    sample_row_t directed[N_DIRECTED] = '{
        '{32'sh7fffffff, 1'b1, 33'sh0fffffffe, 11'd1},
        '{32'sh7fffffff, 1'b1, 33'sh0fffffffe, 11'd2},
        '{32'sh80000000, 1'b1, 33'sh0fffffffe, 11'd3},
        '{32'sh80000000, 1'b1, -33'sh1, 11'd4},
        '{32'sh80000000, 1'b0, '0, '0},
        '{32'sh80000000, 1'b0, '0, '0},
        '{32'sh00000000, 1'b0, '0, '0},
        '{32'shffffffff, 1'b0, '0, '0},
        '{32'sh00000001, 1'b0, '0, '0},
        '{32'sh00000001, 1'b0, '0, '0},
        '{32'sh55555555, 1'b0, '0, '0},
        '{32'shaaaaaaaa, 1'b0, '0, '0},
        '{32'sh7ffffffe, 1'b0, '0, '0},
        '{32'sh80000001, 1'b0, '0, '0},
        '{32'sh00000000, 1'b0, '0, '0},
        '{32'sh00000000, 1'b0, '0, '0}
    };

    initial
    begin
        int mode;
        sample_ch.valid = 1'b0;
        sample_ch.value = '0;
        result_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        recv_idle = 70;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_sample(directed[i].value);
            if (directed[i].known && (pending[$].median_x2 !== directed[i].median_x2
                || pending[$].count !== directed[i].count))
            begin
                $display("%0t: table row %0d expected %0d/%0d, predictor %0d/%0d", $time, i,
                         directed[i].median_x2, directed[i].count,
                         pending[$].median_x2, pending[$].count);
                errors++;
            end
        end
        drain_results();

        // receiver held off while items keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 10; i++)
                    send_sample(rand_value(0));
            end
        join
        drain_results();

        mode = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                send_idle = 70; recv_idle = 27;
            end
            if (i == 2 * N_RANDOM / 3)
            begin
                drain_results();
                send_idle = 0; recv_idle = 0;
            end
            if (i % 50 == 0)
                mode = $urandom_range(3, 0);
            send_sample(rand_value(mode));
        end
        drain_results();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
